### rtl/zvd_pkg.sv
// ============================================================================
// zvd_pkg
// Shared types and codes for the zigzag varint value decoder.
// ============================================================================
package zvd_pkg;

    localparam logic [2:0] KIND_LONG   = 3'd0;
    localparam logic [2:0] KIND_INT    = 3'd1;
    localparam logic [2:0] KIND_LENGTH = 3'd2;
    localparam logic [2:0] KIND_BOOL   = 3'd3;
    localparam logic [2:0] KIND_COUNT  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_LONG   = 3'd1;
    localparam logic [2:0] ST_INT_RANGE  = 3'd2;
    localparam logic [2:0] ST_NEG_LENGTH = 3'd3;
    localparam logic [2:0] ST_BAD_BOOL   = 3'd4;
    localparam logic [2:0] ST_MIN_COUNT  = 3'd5;
    localparam logic [2:0] ST_NEG_SIZE   = 3'd6;

    localparam logic [7:0]  CONT_BIT     = 8'h80;
    localparam logic [6:0]  GROUP_MASK   = 7'h7f;
    localparam logic [3:0]  LAST_INDEX   = 4'd9;
    localparam logic [63:0] SIGN_BIT     = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] value;
        logic [2:0]         status;
        logic               has_byte_size;
        logic [62:0]        byte_size;
    } t_out_word;

endpackage

### rtl/zvd_core.sv
// ============================================================================
// zvd_core
// Varint gather, zigzag decode and kind checks, with the decode state.
// ============================================================================
module zvd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  zvd_pkg::t_in_word i_word,
    output logic              o_emit,
    output zvd_pkg::t_out_word o_result
);
    import zvd_pkg::*;

    logic [63:0] r_acc,   n_acc;
    logic [3:0]  r_index, n_index;
    logic        r_in_value, n_in_value;
    logic [2:0]  r_kind,  n_kind;
    logic        r_second, n_second;
    logic [63:0] r_saved, n_saved;

    logic        start;
    logic [2:0]  kind;
    logic [3:0]  index;
    logic        second;
    logic [63:0] acc_base;
    logic [63:0] group_shifted;
    logic [63:0] acc;
    logic [63:0] v;
    logic        fits_int;
    logic [7:0]  b;

    assign b        = i_word.data_byte;
    assign start    = !r_in_value;
    assign kind     = start ? i_word.action : r_kind;
    assign index    = start ? 4'd0 : r_index;
    assign second   = start ? 1'b0 : r_second;
    assign acc_base = start ? 64'd0 : r_acc;

    always_comb begin
        group_shifted = '0;
        unique case (index)
            4'd0:    group_shifted = {57'd0, b[6:0] & GROUP_MASK};
            4'd1:    group_shifted = {50'd0, b[6:0], 7'd0};
            4'd2:    group_shifted = {43'd0, b[6:0], 14'd0};
            4'd3:    group_shifted = {36'd0, b[6:0], 21'd0};
            4'd4:    group_shifted = {29'd0, b[6:0], 28'd0};
            4'd5:    group_shifted = {22'd0, b[6:0], 35'd0};
            4'd6:    group_shifted = {15'd0, b[6:0], 42'd0};
            4'd7:    group_shifted = {8'd0, b[6:0], 49'd0};
            4'd8:    group_shifted = {1'b0, b[6:0], 56'd0};
            4'd9:    group_shifted = {b[0], 63'd0};
            default: group_shifted = '0;
        endcase
    end

    assign acc      = acc_base | group_shifted;
    assign v        = {1'b0, acc[63:1]} ^ {64{acc[0]}};
    assign fits_int = (&v[63:31]) || !(|v[63:31]);

    always_comb begin
        n_acc      = r_acc;
        n_index    = r_index;
        n_in_value = r_in_value;
        n_kind     = start ? i_word.action : r_kind;
        n_second   = r_second;
        n_saved    = r_saved;
        o_emit     = 1'b0;
        o_result   = '0;

        if (start && kind == KIND_BOOL) begin
            o_emit = 1'b1;
            if (b == 8'd0 || b == 8'd1) begin
                o_result.value = $signed({56'd0, b});
            end else begin
                o_result.status = ST_BAD_BOOL;
            end
        end else if ((b & CONT_BIT) != 8'd0) begin
            if (index >= LAST_INDEX) begin
                o_emit          = 1'b1;
                o_result.status = ST_TOO_LONG;
            end else begin
                n_acc      = acc;
                n_index    = index + 4'd1;
                n_in_value = 1'b1;
                n_second   = second;
            end
        end else begin
            o_emit = 1'b1;
            case (kind)
                KIND_INT: begin
                    if (!fits_int) begin
                        o_result.status = ST_INT_RANGE;
                    end else begin
                        o_result.value = $signed(v);
                    end
                end
                KIND_LENGTH: begin
                    if (!fits_int) begin
                        o_result.status = ST_INT_RANGE;
                    end else if (v[63]) begin
                        o_result.status = ST_NEG_LENGTH;
                    end else begin
                        o_result.value = $signed(v);
                    end
                end
                KIND_COUNT: begin
                    if (second) begin
                        if (v[63]) begin
                            o_result.status = ST_NEG_SIZE;
                        end else begin
                            o_result.value         = $signed(64'd0 - r_saved);
                            o_result.has_byte_size = 1'b1;
                            o_result.byte_size     = v[62:0];
                        end
                    end else if (v[63]) begin
                        if (v == SIGN_BIT) begin
                            o_result.status = ST_MIN_COUNT;
                        end else begin
                            o_emit     = 1'b0;
                            n_saved    = v;
                            n_second   = 1'b1;
                            n_in_value = 1'b1;
                            n_acc      = '0;
                            n_index    = '0;
                        end
                    end else begin
                        o_result.value = $signed(v);
                    end
                end
                default: begin
                    o_result.value = $signed(v);
                end
            endcase
        end

        if (o_emit) begin
            n_acc      = '0;
            n_index    = '0;
            n_in_value = 1'b0;
            n_second   = 1'b0;
            n_saved    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_index    <= '0;
            r_in_value <= 1'b0;
            r_kind     <= KIND_LONG;
            r_second   <= 1'b0;
            r_saved    <= '0;
        end else if (i_step) begin
            r_acc      <= n_acc;
            r_index    <= n_index;
            r_in_value <= n_in_value;
            r_kind     <= n_kind;
            r_second   <= n_second;
            r_saved    <= n_saved;
        end
    end

endmodule

### rtl/zigzag_varint_value_decoder.sv
// ============================================================================
// zigzag_varint_value_decoder
// Byte-serial zigzag varint decoder with per-value kind checks.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one stream byte
//   per word, with the value kind; the kind is sampled at a value's first byte.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives one word per
//   finished or failed value: decoded value, status, and block byte size.
//   Throughput: one byte per cycle while the output is not stalled; the
//   decode step is a single pass of shift-or and compare logic between the
//   input and result registers. An accepted byte waits in the input register;
//   its result word goes to the output register, which drives o_out_valid.
//   Bytes that end no value produce no output word.
//   Reset clears both valid flags and the decode state; the block is idle.
//   When the receiver stalls, the result stays in the output register, one
//   more byte is held in the input register, then o_in_ready drops until the
//   result is taken.
// ============================================================================
module zigzag_varint_value_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  zvd_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output zvd_pkg::t_out_word o_out_data
);
    import zvd_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      step;
    logic      emit;
    t_out_word result;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    zvd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_data;
        end
        if (step && emit) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

endmodule
